>>> hdl/mscs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscs_pkg
// Shared constants, types and helpers for the marching squares segment unit.
// ----------------------------------------------------------------------------
package mscs_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
  localparam int SIZE_BITS   = 11;
  localparam int POS_BITS    = 10;
  localparam int FRAC_BITS   = 16;
  localparam int CFG_BITS    = 16;
  localparam int IDX_BITS    = 2;
  localparam int DIV_CNT_BITS = $clog2(FRAC_BITS + 1);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [FRAC_BITS-1:0]   frac_t;
  typedef logic [1:0]             edge_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_THRESHOLD   = 2'd0,
    REG_GRID_WIDTH  = 2'd1,
    REG_GRID_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CLASS,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic capture;    // take the input request
    logic classify;   // corners ready: classify, write line buffer, step counters
    logic div_start;  // launch one crossing fraction
    logic store_frac; // divider done: keep its result
    logic seg;        // segment being built
    logic ep;         // 0 first endpoint, 1 second
    logic load;       // move segment into the output register
    logic last;       // final segment of this sample
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] nseg;
    logic       div_busy;
    logic       out_free;
  } ctrl_sts_t;

  function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v,
                                                      input int maxv);
    logic [SIZE_BITS-1:0] r;
    if (v < SIZE_BITS'(2)) r = SIZE_BITS'(2);
    else if (v > SIZE_BITS'(maxv)) r = SIZE_BITS'(maxv);
    else r = v;
    return r;
  endfunction

  function automatic sample_t abs_diff(input sample_t a, input sample_t b);
    logic signed [SAMPLE_BITS:0] d;
    logic [SAMPLE_BITS:0] m;
    d = $signed({a[SAMPLE_BITS-1], a}) - $signed({b[SAMPLE_BITS-1], b});
    m = d[SAMPLE_BITS] ? (~d + 1'b1) : d;
    return m[SAMPLE_BITS-1:0];
  endfunction

endpackage

>>> hdl/mscs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscs_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mscs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/mscs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscs_div
// Bit-serial restoring divider: floor(d0 * 2^16 / (d0 + d1)), saturating.
// ----------------------------------------------------------------------------
module mscs_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  mscs_pkg::sample_t       d0,
  input  mscs_pkg::sample_t       d1,
  output logic                    busy,
  output mscs_pkg::frac_t         quot
);
  import mscs_pkg::*;

  logic [SAMPLE_BITS:0]    den_r, rem_r;
  frac_t                   q_r;
  logic                    sat_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;
  logic                    busy_r;
  logic [SAMPLE_BITS+1:0]  shl;
  logic                    ge;

  assign shl  = {rem_r, 1'b0};
  assign ge   = shl >= {1'b0, den_r};
  assign busy = busy_r;
  assign quot = sat_r ? '1 : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_BITS'(FRAC_BITS);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= cnt_r != DIV_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= {1'b0, d0} + {1'b0, d1};
      rem_r <= {1'b0, d0};
      q_r   <= '0;
      sat_r <= d1 == '0;   // crossing lands on the end corner
    end else if (busy_r) begin
      // remainder stays below the divisor, which needs the full 17 bits
      rem_r <= ge ? (SAMPLE_BITS+1)'(shl - {1'b0, den_r})
                  : shl[SAMPLE_BITS:0];
      q_r   <= {q_r[FRAC_BITS-2:0], ge};
    end
  end

endmodule

>>> hdl/mscs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscs_dp
// Datapath: config registers, line buffer, corner window, classifier,
// fraction divider and output register.
// ----------------------------------------------------------------------------
module mscs_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mscs_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [mscs_pkg::CFG_BITS-1:0] cfg_wdata,
  input  mscs_pkg::sample_t             in_sample,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [mscs_pkg::POS_BITS-1:0] out_cell_row,
  output logic [mscs_pkg::POS_BITS-1:0] out_cell_col,
  output mscs_pkg::edge_t               out_edge_a,
  output mscs_pkg::frac_t               out_frac_a,
  output mscs_pkg::edge_t               out_edge_b,
  output mscs_pkg::frac_t               out_frac_b,
  output logic                          out_last_of_cell,
  input  mscs_pkg::ctrl_cmd_t           cmd,
  output mscs_pkg::ctrl_sts_t           sts
);
  import mscs_pkg::*;

  sample_t              thr_r;
  logic [SIZE_BITS-1:0] width_r, height_r, w_eff, h_eff;
  sample_t              sample_r, left_r, ul_r, ram_rdata;
  logic [COL_BITS-1:0]  col_r;
  logic [ROW_BITS-1:0]  row_r;
  logic [POS_BITS-1:0]  cell_row_r, cell_col_r;
  sample_t              v_r [4];
  sample_t              v_in [4];
  logic [3:0]           st;
  logic [2:0]           cnt;
  logic [1:0]           nseg_r, nseg_nxt;
  edge_t                ea0_r, eb0_r, ea1_r, eb1_r;
  edge_t                ea0_nxt, eb0_nxt, c;
  edge_t                e_sel, e_next;
  frac_t                frac_a_r, frac_b_r, quot;
  logic                 div_busy;
  logic [SIZE_BITS-1:0] col_inc, row_inc;
  logic                 out_valid_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= '0;
      width_r  <= SIZE_BITS'(MAX_WIDTH);
      height_r <= SIZE_BITS'(MAX_HEIGHT);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD:   thr_r    <= cfg_wdata[SAMPLE_BITS-1:0];
        REG_GRID_WIDTH:  width_r  <= cfg_wdata[SIZE_BITS-1:0];
        REG_GRID_HEIGHT: height_r <= cfg_wdata[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = clamp_size(width_r, MAX_WIDTH);
  assign h_eff = clamp_size(height_r, MAX_HEIGHT);

  mscs_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_line (
    .clk   (clk),
    .we    (cmd.classify),
    .waddr (col_r),
    .wdata (sample_r),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // classification
  assign v_in[0] = ul_r;
  assign v_in[1] = ram_rdata;
  assign v_in[2] = sample_r;
  assign v_in[3] = left_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      st[k] = $signed(v_in[k]) > $signed(thr_r);
    end
    cnt      = 3'($countones(st));
    nseg_nxt = 2'd0;
    ea0_nxt  = 2'd0;
    eb0_nxt  = 2'd1;
    c        = 2'd3;
    case (cnt)
      3'd1, 3'd3: begin
        if (st[0] == (cnt == 3'd1)) c = 2'd0;
        else if (st[1] == (cnt == 3'd1)) c = 2'd1;
        else if (st[2] == (cnt == 3'd1)) c = 2'd2;
        nseg_nxt = 2'd1;
        ea0_nxt  = c;
        eb0_nxt  = c + 2'd3;
      end
      3'd2: begin
        if (st[1] != st[2] && st[2] != st[3]) begin
          nseg_nxt = 2'd2;   // saddle: edges 0-1 then 2-3
        end else begin
          if (st[0] == st[1]) c = 2'd0;
          else if (st[1] == st[2]) c = 2'd1;
          else c = 2'd2;
          nseg_nxt = 2'd1;
          ea0_nxt  = c + 2'd3;
          eb0_nxt  = c + 2'd1;
        end
      end
      default: ;
    endcase
    if (row_r == '0 || col_r == '0) nseg_nxt = 2'd0;
  end

  assign col_inc = SIZE_BITS'(col_r) + 1'b1;
  assign row_inc = SIZE_BITS'(row_r) + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      ul_r   <= '0;
      col_r  <= '0;
      row_r  <= '0;
      nseg_r <= '0;
    end else if (cmd.classify) begin
      left_r <= sample_r;
      ul_r   <= ram_rdata;
      nseg_r <= nseg_nxt;
      if (col_inc >= w_eff) begin
        col_r <= '0;
        row_r <= (row_inc >= h_eff) ? '0 : row_inc[ROW_BITS-1:0];
      end else begin
        col_r <= col_inc[COL_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) sample_r <= in_sample;
    if (cmd.classify) begin
      for (int k = 0; k < 4; k++) v_r[k] <= v_in[k];
      cell_row_r <= POS_BITS'(row_r);
      cell_col_r <= POS_BITS'(col_r);
      ea0_r <= ea0_nxt;
      eb0_r <= eb0_nxt;
      ea1_r <= 2'd2;
      eb1_r <= 2'd3;
    end
  end

  // crossing fractions
  always_comb begin
    if (cmd.seg) e_sel = cmd.ep ? eb1_r : ea1_r;
    else         e_sel = cmd.ep ? eb0_r : ea0_r;
    e_next = e_sel + 2'd1;
  end

  mscs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .d0    (abs_diff(v_r[e_sel], thr_r)),
    .d1    (abs_diff(v_r[e_next], thr_r)),
    .busy  (div_busy),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.store_frac) begin
      if (cmd.ep) frac_b_r <= quot;
      else        frac_a_r <= quot;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_cell_row     <= cell_row_r;
      out_cell_col     <= cell_col_r;
      out_edge_a       <= cmd.seg ? ea1_r : ea0_r;
      out_edge_b       <= cmd.seg ? eb1_r : eb0_r;
      out_frac_a       <= frac_a_r;
      out_frac_b       <= frac_b_r;
      out_last_of_cell <= cmd.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign sts.nseg      = nseg_r;
  assign sts.div_busy  = div_busy;
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

>>> hdl/mscs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscs_ctrl
// Sequencer: read, classify, then two fractions and one load per segment.
// ----------------------------------------------------------------------------
module mscs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mscs_pkg::ctrl_sts_t sts,
  output mscs_pkg::ctrl_cmd_t cmd
);
  import mscs_pkg::*;

  state_t state_r, state_nxt;
  logic   seg_r, seg_nxt, ep_r, ep_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      seg_r   <= 1'b0;
      ep_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seg_r   <= seg_nxt;
      ep_r    <= ep_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    seg_nxt   = seg_r;
    ep_nxt    = ep_r;
    cmd       = '0;
    cmd.seg   = seg_r;
    cmd.ep    = ep_r;
    cmd.last  = seg_r || sts.nseg == 2'd1;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_CLASS;
      ST_CLASS: begin
        cmd.classify = 1'b1;
        seg_nxt      = 1'b0;
        ep_nxt       = 1'b0;
        state_nxt    = ST_DIV_START;
      end
      ST_DIV_START: begin
        if (sts.nseg == 2'd0) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV_RUN;
        end
      end
      ST_DIV_RUN: begin
        if (!sts.div_busy) begin
          cmd.store_frac = 1'b1;
          ep_nxt         = ~ep_r;
          state_nxt      = ep_r ? ST_LOAD : ST_DIV_START;
        end
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          if (cmd.last) begin
            state_nxt = ST_IDLE;
          end else begin
            seg_nxt   = 1'b1;
            state_nxt = ST_DIV_START;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> hdl/marching_squares_cell_segments_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marching_squares_cell_segments_unit
// Streams grid samples and emits the isoline segments of each grid cell.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid/in_ready  | in_sample
//  out     | out_valid/out_ready| cell_row, cell_col, edge/frac a+b, last
//  cfg     | cfg_we (no wait)   | cfg_index, cfg_wdata
//
//  A request with no crossing passes through accept, line buffer read,
//  classify and plan check. Each segment adds two serial divisions
//  (launch, then the run state) and a load; all divisions run one at a
//  time on the single shared divider.
//  Synchronous active-low reset clears counters, left/upper-left samples
//  and config; the line buffer holds no reset value and needs no sweep.
//  The output register lets the next request be taken while a result
//  waits; a stalled out channel holds the sequencer only at segment load.
// ----------------------------------------------------------------------------
module marching_squares_cell_segments_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mscs_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [mscs_pkg::CFG_BITS-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mscs_pkg::sample_t             in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mscs_pkg::POS_BITS-1:0] out_cell_row,
  output logic [mscs_pkg::POS_BITS-1:0] out_cell_col,
  output mscs_pkg::edge_t               out_edge_a,
  output mscs_pkg::frac_t               out_frac_a,
  output mscs_pkg::edge_t               out_edge_b,
  output mscs_pkg::frac_t               out_frac_b,
  output logic                          out_last_of_cell
);
  import mscs_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer: owns the input handshake and steps the datapath
  mscs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: line buffer, corner window, divider, output register
  mscs_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_sample        (in_sample),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_cell_row     (out_cell_row),
    .out_cell_col     (out_cell_col),
    .out_edge_a       (out_edge_a),
    .out_frac_a       (out_frac_a),
    .out_edge_b       (out_edge_b),
    .out_frac_b       (out_frac_b),
    .out_last_of_cell (out_last_of_cell),
    .cmd              (cmd),
    .sts              (sts)
  );

`ifndef SYNTHESIS
  // no division may still run when a new request is taken
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.div_busy) else $error("divider busy while idle");

  // a segment is only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> sts.out_free) else $error("output overwritten");

  // every emitted cell lies at row and column one or more
  a_cell_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cell_row != '0 && out_cell_col != '0))
    else $error("segment for border point");
`endif

endmodule
